// ===== hw/rtl/hlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hlt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 2048;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths.
   localparam int IP_W       = 32;
   localparam int MAC_W      = 48;
   localparam int CONF_W     = 2;
   localparam int MIN_CONF_W = 8;
   localparam int EVENT_W    = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   // Highest confidence level; a code of 3 saturates to it.
   localparam logic [CONF_W-1:0] CONF_MAX = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRE_MAC = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_FLOOR  = 8'd1;

   // Result event codes.
   localparam logic [EVENT_W-1:0] EV_HIT_SILENT    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_HIT_CHANGED   = 3'd1;
   localparam logic [EVENT_W-1:0] EV_NEW_REPORTED  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_NEW_SILENT    = 3'd3;
   localparam logic [EVENT_W-1:0] EV_DROPPED_FULL  = 3'd4;

   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic [CONF_W-1:0] conf;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // latch the incoming observation, restart the scan
      logic scan_rd;      // read the next table entry
      logic commit_hit;   // update the matched entry and load the result
      logic commit_miss;  // append or drop, and load the result
   } hlt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;     // entries remain to be read
      logic pending;  // a read entry waits for comparison
      logic hit;      // the entry under comparison matches the address
   } hlt_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hlt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlt_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  hlt_pkg::hlt_sts_type sts,
   output hlt_pkg::hlt_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT_HIT,
      ST_COMMIT_MISS
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.load        = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_rd     = (state_ff == ST_SCAN) && sts.more && !sts.hit;
      cmd.commit_hit  = (state_ff == ST_COMMIT_HIT) && out_free;
      cmd.commit_miss = (state_ff == ST_COMMIT_MISS) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.hit) begin
               state_in = ST_COMMIT_HIT;
            end else if (!sts.more && !sts.pending) begin
               state_in = ST_COMMIT_MISS;
            end
         end
         ST_COMMIT_HIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_COMMIT_MISS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit_hit || cmd.commit_miss) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never loaded over one that has not been taken.
   a_commit_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_hit || cmd.commit_miss) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded while the output register was occupied");

   // No further read is issued once a match has been found.
   a_no_read_on_hit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan_rd && sts.hit))
      else $error("table read issued in the cycle of a match");

   // An accepted observation always starts a scan.
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN))
      else $error("accepted observation did not start a scan");

endmodule

`default_nettype wire

// ===== hw/rtl/hlt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlt_datapath (
   input  wire                                       clock,
   input  wire                                       reset,
   input  hlt_pkg::hlt_cmd_type                      cmd,
   output hlt_pkg::hlt_sts_type                      sts,
   input  wire  [hlt_pkg::IP_W-1:0]                  req_ip_address,
   input  wire                                       req_mac_present,
   input  wire  [hlt_pkg::MAC_W-1:0]                 req_mac_address,
   input  wire  [hlt_pkg::CONF_W-1:0]                req_confidence,
   input  wire                                       csr_write,
   input  wire  [hlt_pkg::CSR_IDX_W-1:0]             csr_index,
   input  wire  [hlt_pkg::CSR_DATA_W-1:0]            csr_data,
   output logic [hlt_pkg::EVENT_W-1:0]               rsp_event_res,
   output logic [hlt_pkg::IDX_W-1:0]                 rsp_slot,
   output logic [hlt_pkg::CONF_W-1:0]                rsp_stored_confidence,
   output logic [hlt_pkg::CNT_W-1:0]                 rsp_entry_count
);

   hlt_pkg::entry_type host_mem [hlt_pkg::TABLE_DEPTH];

   // Latched observation.
   logic [hlt_pkg::IP_W-1:0]       obs_ip_ff;
   logic                           obs_has_mac_ff;
   logic [hlt_pkg::MAC_W-1:0]      obs_mac_ff;
   logic [hlt_pkg::CONF_W-1:0]     obs_conf_ff;
   logic [hlt_pkg::CONF_W-1:0]     obs_conf_in;

   // Scan pipeline.
   logic [hlt_pkg::CNT_W-1:0]      scan_addr_ff;
   logic                           cmp_valid_ff;
   logic [hlt_pkg::IDX_W-1:0]      cmp_addr_ff;
   hlt_pkg::entry_type             rd_data_ff;

   // Control state.
   logic [hlt_pkg::CNT_W-1:0]      count_ff;
   logic [hlt_pkg::CNT_W-1:0]      count_in;
   logic                           require_mac_ff;
   logic [hlt_pkg::MIN_CONF_W-1:0] min_conf_ff;

   // Result register.
   logic [hlt_pkg::EVENT_W-1:0]    rsp_event_ff;
   logic [hlt_pkg::IDX_W-1:0]      rsp_slot_ff;
   logic [hlt_pkg::CONF_W-1:0]     rsp_conf_ff;
   logic [hlt_pkg::CNT_W-1:0]      rsp_count_ff;
   logic [hlt_pkg::EVENT_W-1:0]    rsp_event_in;
   logic [hlt_pkg::IDX_W-1:0]      rsp_slot_in;
   logic [hlt_pkg::CONF_W-1:0]     rsp_conf_in;

   // Commit logic.
   logic                           full;
   logic                           mac_ok;
   logic [hlt_pkg::CONF_W-1:0]     hit_conf;
   logic                           mac_changed;
   logic                           hit_report;
   logic                           new_report;
   logic                           wr_en;
   logic [hlt_pkg::IDX_W-1:0]      wr_addr;
   hlt_pkg::entry_type             wr_data;

   assign sts.more    = (scan_addr_ff < count_ff);
   assign sts.pending = cmp_valid_ff;
   assign sts.hit     = cmp_valid_ff && (rd_data_ff.ip == obs_ip_ff);

   assign obs_conf_in = (req_confidence > hlt_pkg::CONF_MAX) ? hlt_pkg::CONF_MAX
                                                             : req_confidence;

   assign full   = (count_ff == hlt_pkg::CNT_W'(hlt_pkg::TABLE_DEPTH));
   assign mac_ok = !require_mac_ff || obs_has_mac_ff;

   always_comb begin
      hit_conf    = (obs_conf_ff > rd_data_ff.conf) ? obs_conf_ff : rd_data_ff.conf;
      mac_changed = obs_has_mac_ff && (rd_data_ff.mac != obs_mac_ff);
      hit_report  = mac_changed && mac_ok &&
                    ({{(hlt_pkg::MIN_CONF_W - hlt_pkg::CONF_W){1'b0}}, hit_conf}
                     >= min_conf_ff);
      new_report  = mac_ok &&
                    ({{(hlt_pkg::MIN_CONF_W - hlt_pkg::CONF_W){1'b0}}, obs_conf_ff}
                     >= min_conf_ff);

      wr_en   = cmd.commit_hit || (cmd.commit_miss && !full);
      wr_addr = cmd.commit_hit ? cmp_addr_ff : count_ff[hlt_pkg::IDX_W-1:0];
      if (cmd.commit_hit) begin
         wr_data.ip   = rd_data_ff.ip;
         wr_data.mac  = mac_changed ? obs_mac_ff : rd_data_ff.mac;
         wr_data.conf = hit_conf;
      end else begin
         wr_data.ip   = obs_ip_ff;
         wr_data.mac  = obs_has_mac_ff ? obs_mac_ff : '0;
         wr_data.conf = obs_conf_ff;
      end

      count_in     = count_ff;
      rsp_event_in = hlt_pkg::EV_DROPPED_FULL;
      rsp_slot_in  = '0;
      rsp_conf_in  = '0;
      if (cmd.commit_hit) begin
         rsp_event_in = hit_report ? hlt_pkg::EV_HIT_CHANGED : hlt_pkg::EV_HIT_SILENT;
         rsp_slot_in  = cmp_addr_ff;
         rsp_conf_in  = hit_conf;
      end else if (cmd.commit_miss && !full) begin
         rsp_event_in = new_report ? hlt_pkg::EV_NEW_REPORTED : hlt_pkg::EV_NEW_SILENT;
         rsp_slot_in  = count_ff[hlt_pkg::IDX_W-1:0];
         rsp_conf_in  = obs_conf_ff;
         count_in     = count_ff + 1'b1;
      end
   end

   // Table memory: one read port with registered data, one write port.
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         rd_data_ff <= host_mem[scan_addr_ff[hlt_pkg::IDX_W-1:0]];
      end
      if (wr_en) begin
         host_mem[wr_addr] <= wr_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         obs_ip_ff      <= req_ip_address;
         obs_has_mac_ff <= req_mac_present;
         obs_mac_ff     <= req_mac_address;
         obs_conf_ff    <= obs_conf_in;
      end
      if (cmd.scan_rd) begin
         cmp_addr_ff <= scan_addr_ff[hlt_pkg::IDX_W-1:0];
      end
      if (cmd.commit_hit || cmd.commit_miss) begin
         rsp_event_ff <= rsp_event_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_conf_ff  <= rsp_conf_in;
         rsp_count_ff <= count_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff   <= '0;
         cmp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         require_mac_ff <= 1'b0;
         min_conf_ff    <= '0;
      end else begin
         if (cmd.load) begin
            scan_addr_ff <= '0;
         end else if (cmd.scan_rd) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
         end
         cmp_valid_ff <= cmd.scan_rd;
         count_ff     <= count_in;
         if (csr_write && (csr_index == hlt_pkg::CSR_REQUIRE_MAC)) begin
            require_mac_ff <= csr_data[0];
         end
         if (csr_write && (csr_index == hlt_pkg::CSR_CONF_FLOOR)) begin
            min_conf_ff <= csr_data;
         end
      end
   end

   assign rsp_event_res         = rsp_event_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_stored_confidence = rsp_conf_ff;
   assign rsp_entry_count       = rsp_count_ff;

   // The entry count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hlt_pkg::CNT_W'(hlt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // The entry count only ever grows by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("entry count changed by other than one");

   // Reads never go past the valid entries.
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> (scan_addr_ff < count_ff))
      else $error("table read beyond the valid entries");

endmodule

`default_nettype wire

// ===== hw/rtl/ip_host_learning_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Beat contents
// req_      in         req_valid / req_ready  ip_address, mac_present, mac_address, confidence
// rsp_      out        rsp_valid / rsp_ready  event_res, slot, stored_confidence, entry_count
// csr_      in         csr_valid / csr_ready  index (0 require_mac, 1 confidence floor), data
//
// An observation reads the host table entry by entry until a match is found (all valid
// entries, up to 2048, on a miss); the single read port of the host table sets this pace,
// one entry per cycle.
// Reset clears the entry count and configuration; the table contents need no clearing.
// A new beat is accepted as soon as the previous one has been committed, even while its
// result still sits in the output register; only the commit waits on a stalled rsp_ready.
// Configuration beats are always accepted and should be sent only while the block is idle.
module ip_host_learning_table_core (
   input  wire                                clock,
   input  wire                                reset,

   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [hlt_pkg::IP_W-1:0]           req_ip_address,
   input  wire                                req_mac_present,
   input  wire  [hlt_pkg::MAC_W-1:0]          req_mac_address,
   input  wire  [hlt_pkg::CONF_W-1:0]         req_confidence,

   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [hlt_pkg::EVENT_W-1:0]        rsp_event_res,
   output logic [hlt_pkg::IDX_W-1:0]          rsp_slot,
   output logic [hlt_pkg::CONF_W-1:0]         rsp_stored_confidence,
   output logic [hlt_pkg::CNT_W-1:0]          rsp_entry_count,

   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [hlt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [hlt_pkg::CSR_DATA_W-1:0]     csr_data
);

   hlt_pkg::hlt_cmd_type cmd;
   hlt_pkg::hlt_sts_type sts;

   // Register writes complete in the cycle they are presented.
   assign csr_ready = 1'b1;

   // The controller sequences accept, scan, commit; it owns both handshakes.
   hlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the host table, the scan pipeline, the configuration
   // registers and the result register.
   hlt_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_ip_address        (req_ip_address),
      .req_mac_present       (req_mac_present),
      .req_mac_address       (req_mac_address),
      .req_confidence        (req_confidence),
      .csr_write             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_event_res         (rsp_event_res),
      .rsp_slot              (rsp_slot),
      .rsp_stored_confidence (rsp_stored_confidence),
      .rsp_entry_count       (rsp_entry_count)
   );

endmodule

`default_nettype wire
